/* rtl/ascending_sort_engine_assert.svh */
// assertion macros for the ascending sort engine checker
// depends on a clock named clock and a synchronous active-high reset named reset
`ifndef ASCENDING_SORT_ENGINE_ASSERT_SVH
`define ASCENDING_SORT_ENGINE_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define ASE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication into the next cycle
`define ASE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ase_pkg.sv */
// shared types and constants for the ascending sort engine
// no dependencies
package ase_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] elem_type;

   // per-cell control, broadcast from the top level to every cell
   typedef struct packed {
      logic     insert;
      logic     shift;
      elem_type new_value;
   } cell_ctrl_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

endpackage

/* rtl/ase_cell.sv */
// one insertion cell of the sorting chain: holds one element and its occupied bit
// depends on ase_pkg
module ase_cell import ase_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          left_occ,
   input  logic          left_gt,
   input  elem_type      left_value,
   input  logic          right_occ,
   input  elem_type      right_value,
   output logic          occ,
   output logic          gt,
   output elem_type      value
);

   logic     occ_ff;
   logic     occ_in;
   elem_type value_ff;
   elem_type value_in;

   // an empty cell ranks above any incoming value
   assign gt    = !occ_ff || (value_ff > ctrl.new_value);
   assign occ   = occ_ff;
   assign value = value_ff;

   // insert: cells above the new value move up one place, the boundary cell takes it
   // shift: whole chain moves down one place toward the output
   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      if (ctrl.insert) begin
         if (gt) begin
            value_in = left_gt ? left_value : ctrl.new_value;
         end
         occ_in = occ_ff | left_occ;
      end else if (ctrl.shift) begin
         value_in = right_value;
         occ_in   = right_occ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* rtl/ascending_sort_engine.sv */
// top level of the ascending sort engine: insertion cell chain and load/drain control
// depends on ase_pkg and ase_cell
//
// Usage:
//  - req channel: one signed 32-bit element per beat, req_last marks the final
//    element of a block. Beats are taken one per cycle while loading; each
//    element is inserted into a chain of 64 cells that keeps the block sorted.
//  - Elements beyond 64 are dropped and rsp_overflow is set on every result
//    beat of that block.
//  - After the beat with req_last, results start on the next cycle: the cell
//    at the head of the chain is the output register, and each taken rsp beat
//    moves the whole chain down by one. One result per cycle when rsp_stall
//    stays low.
//  - rsp_last_out marks the final result of the block.
//  - req_stall is high while results are being delivered; the next block
//    is taken once the last result beat has gone.
//  - A stalled result holds its payload; the chain does not move.
//  - Synchronous reset empties the chain and clears the overflow flag.
module ascending_sort_engine import ase_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  elem_type req_value,
   input  logic     req_last,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output elem_type rsp_sorted_value,
   output logic     rsp_last_out,
   output logic     rsp_overflow
);

   state_type     state_ff;
   state_type     state_in;
   logic          ovf_ff;
   logic          ovf_in;
   cell_ctrl_type ctrl;
   logic          req_take;
   logic          rsp_take;
   logic          full;

   logic     cell_occ   [DEPTH];
   logic     cell_gt    [DEPTH];
   elem_type cell_value [DEPTH];

   // chain of cells with fixed ends
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic     l_occ;
      logic     l_gt;
      elem_type l_value;
      logic     r_occ;
      elem_type r_value;

      if (i == 0) begin : g_head
         assign l_occ   = 1'b1;
         assign l_gt    = 1'b0;
         assign l_value = '0;
      end else begin : g_body
         assign l_occ   = cell_occ[i-1];
         assign l_gt    = cell_gt[i-1];
         assign l_value = cell_value[i-1];
      end

      if (i == DEPTH-1) begin : g_tail
         assign r_occ   = 1'b0;
         assign r_value = '0;
      end else begin : g_mid
         assign r_occ   = cell_occ[i+1];
         assign r_value = cell_value[i+1];
      end

      ase_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_occ    (l_occ),
         .left_gt     (l_gt),
         .left_value  (l_value),
         .right_occ   (r_occ),
         .right_value (r_value),
         .occ         (cell_occ[i]),
         .gt          (cell_gt[i]),
         .value       (cell_value[i])
      );
   end

   // handshake and chain control
   assign full             = cell_occ[DEPTH-1];
   assign req_stall        = (state_ff != ST_LOAD);
   assign rsp_valid        = (state_ff == ST_DRAIN) && cell_occ[0];
   assign rsp_sorted_value = cell_value[0];
   assign rsp_last_out     = cell_occ[0] && !cell_occ[1];
   assign rsp_overflow     = ovf_ff;
   assign req_take         = req_valid && !req_stall;
   assign rsp_take         = rsp_valid && !rsp_stall;

   assign ctrl.insert    = req_take && !full;
   assign ctrl.shift     = rsp_take;
   assign ctrl.new_value = req_value;

   // load/drain sequencing and overflow tracking
   always_comb begin
      state_in = state_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (full) begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_take && rsp_last_out) begin
               state_in = ST_LOAD;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

/* rtl/ase_checker.sv */
// port-level checker for the ascending sort engine, bound to the top level
// depends on ase_pkg and ascending_sort_engine_assert.svh
`include "ascending_sort_engine_assert.svh"

module ase_checker import ase_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_stall,
   input logic     req_last,
   input logic     rsp_valid,
   input logic     rsp_stall,
   input elem_type rsp_sorted_value,
   input logic     rsp_last_out,
   input logic     rsp_overflow
);

   logic req_beat;
   logic rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   // no new element is taken while results are pending
   `ASE_ASSERT(a_no_load_in_drain, rsp_valid |-> req_stall, "element taken during drain")

   // the final element starts the result burst on the next cycle
   `ASE_ASSERT_NEXT(a_drain_starts, req_beat && req_last, rsp_valid, "no result after last")

   // the burst ends right after the final result beat
   `ASE_ASSERT_NEXT(a_drain_ends, rsp_beat && rsp_last_out, !rsp_valid, "result after last_out")

   // overflow is one value across a whole burst
   `ASE_ASSERT_NEXT(a_ovf_steady, rsp_beat && !rsp_last_out, rsp_overflow == $past(rsp_overflow),
      "overflow changed within a burst")

   // a stalled result holds
   `ASE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_sorted_value) && $stable(rsp_last_out), "stalled result changed")

endmodule

bind ascending_sort_engine ase_checker u_ase_checker (.*);

/* sim/ascending_sort_engine_tb.sv */
// testbench for the ascending sort engine: directed blocks, then random blocks
// with bursty sender and patterned receiver stalls, checked against an ordered-queue predictor
// depends on ase_pkg and the ascending_sort_engine rtl
module ascending_sort_engine_tb;
   import ase_pkg::*;

   localparam elem_type ELEM_MIN     = 32'sh8000_0000;
   localparam elem_type ELEM_MAX     = 32'sh7fff_ffff;
   localparam int       RANDOM_ITEMS = 420;
   localparam int       IDLE_LIMIT   = 2000;
   localparam int       DRAIN_CYCLES = 100;
   localparam int       ROW_COUNT    = 19;

   // one sorted beat as it should leave the block
   typedef struct packed {
      elem_type value;
      logic     last_out;
      logic     overflow;
   } sorted_beat_type;

   // one directed element; known rows are single-element blocks with the result typed in
   typedef struct packed {
      elem_type value;
      logic     last;
      logic     known;
      elem_type want;
   } directed_row_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   elem_type req_value = '0;
   logic     req_last = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   elem_type rsp_sorted_value;
   logic     rsp_last_out;
   logic     rsp_overflow;

   // predictor state: the held block kept in ascending order
   elem_type        held_elems[$];
   logic            held_dropped = 1'b0;
   sorted_beat_type pending_sorted[$];

   int mismatch_count = 0;
   int idle_cycles    = 0;
   int burst_left     = 0;
   int sent_items     = 0;

   directed_row_type directed_rows [0:ROW_COUNT-1] = '{
      '{ELEM_MIN,    1'b1, 1'b1, ELEM_MIN},
      '{ELEM_MAX,    1'b1, 1'b1, ELEM_MAX},
      '{32'sd0,      1'b1, 1'b1, 32'sd0},
      '{-32'sd1,     1'b1, 1'b1, -32'sd1},
      // two elements in reverse order
      '{32'sd2,      1'b0, 1'b0, 32'sd0},
      '{32'sd1,      1'b1, 1'b0, 32'sd0},
      // both extremes, zero and a duplicate in one block
      '{32'sd5,      1'b0, 1'b0, 32'sd0},
      '{-32'sd3,     1'b0, 1'b0, 32'sd0},
      '{ELEM_MAX,    1'b0, 1'b0, 32'sd0},
      '{ELEM_MIN,    1'b0, 1'b0, 32'sd0},
      '{32'sd0,      1'b0, 1'b0, 32'sd0},
      '{-32'sd3,     1'b0, 1'b0, 32'sd0},
      '{32'sd1,      1'b1, 1'b0, 32'sd0},
      // all equal
      '{32'sd7,      1'b0, 1'b0, 32'sd0},
      '{32'sd7,      1'b0, 1'b0, 32'sd0},
      '{32'sd7,      1'b1, 1'b0, 32'sd0},
      // already ascending
      '{-32'sd2,     1'b0, 1'b0, 32'sd0},
      '{-32'sd1,     1'b0, 1'b0, 32'sd0},
      '{32'sd4,      1'b1, 1'b0, 32'sd0}
   };

   ascending_sort_engine i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   // fold one accepted element into the held block, emit the sorted block on last
   function automatic void absorb_element(input elem_type v, input logic l);
      int pos;
      int n;
      pos = held_elems.size();
      if (held_elems.size() < DEPTH) begin
         for (int i = 0; i < held_elems.size(); i++) begin
            if (held_elems[i] > v) begin
               pos = i;
               break;
            end
         end
         held_elems.insert(pos, v);
      end else begin
         held_dropped = 1'b1;
      end
      if (l) begin
         n = held_elems.size();
         for (int k = 0; k < n; k++)
            pending_sorted.push_back('{held_elems[k], (k == n - 1), held_dropped});
         held_elems.delete();
         held_dropped = 1'b0;
      end
   endfunction

   // element mix: extremes, a narrow range for duplicates, 0 or -1, and full-width values
   function automatic elem_type random_element();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return ELEM_MIN;
         1:       return ELEM_MAX;
         2, 3, 4: return elem_type'($signed($urandom_range(0, 15)) - 8);
         5:       return ($urandom_range(0, 1) == 0) ? 32'sd0 : -32'sd1;
         default: return elem_type'($urandom);
      endcase
   endfunction

   // drive a req beat, maybe gapped at a burst end; returns once taken and req_stall is low
   task automatic send_element(input elem_type v, input logic l);
      int gap;
      int pick;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         pick = $urandom_range(0, 9);
         if (pick >= 9)
            gap = $urandom_range(10, 20);
         else if (pick == 8)
            gap = $urandom_range(4, 8);
         else if (pick >= 4)
            gap = $urandom_range(1, 3);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= l;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
   endtask

   // result side: check each taken beat, then pick the next stall value
   always @(posedge clock) begin : rsp_side
      sorted_beat_type want_beat;
      static int pattern_mode = 0;
      static int pattern_left = 0;
      static int run_left     = 0;
      logic      next_stall;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_sorted.size() == 0) begin
            report_mismatch("unexpected beat, value", rsp_sorted_value, 0);
         end else begin
            want_beat = pending_sorted.pop_front();
            if (rsp_sorted_value !== want_beat.value)
               report_mismatch("sorted_value", rsp_sorted_value, want_beat.value);
            if (rsp_last_out !== want_beat.last_out)
               report_mismatch("last_out", rsp_last_out, want_beat.last_out);
            if (rsp_overflow !== want_beat.overflow)
               report_mismatch("overflow", rsp_overflow, want_beat.overflow);
         end
      end
      // stall pattern: free running, sparse random, or long runs
      if (pattern_left == 0) begin
         pattern_mode = $urandom_range(0, 2);
         pattern_left = $urandom_range(20, 200);
      end else begin
         pattern_left--;
      end
      next_stall = 1'b0;
      case (pattern_mode)
         1: next_stall = ($urandom_range(0, 2) == 0);
         2: begin
            if (run_left > 0) begin
               run_left--;
               next_stall = 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
               run_left   = $urandom_range(1, 15);
               next_stall = 1'b1;
            end
         end
         default: next_stall = 1'b0;
      endcase
      rsp_stall <= next_stall;
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL ascending_sort_engine");
         $finish;
      end
   end

   initial begin
      int block_size;
      int pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed blocks
      for (int r = 0; r < ROW_COUNT; r++) begin
         send_element(directed_rows[r].value, directed_rows[r].last);
         if (directed_rows[r].known)
            pending_sorted.push_back('{directed_rows[r].want, 1'b1, 1'b0});
         else
            absorb_element(directed_rows[r].value, directed_rows[r].last);
      end

      // random blocks: mostly short, some full, some overflowing
      while (sent_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            block_size = DEPTH;
         else if (pick == 1)
            block_size = $urandom_range(DEPTH + 1, DEPTH + 6);
         else if (pick == 2)
            block_size = $urandom_range(40, DEPTH - 1);
         else
            block_size = $urandom_range(1, 10);
         for (int k = 0; k < block_size; k++) begin
            elem_type v;
            v = random_element();
            send_element(v, (k == block_size - 1));
            absorb_element(v, (k == block_size - 1));
         end
         sent_items += block_size;
      end
      req_valid <= 1'b0;

      while (pending_sorted.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_sorted.size() == 0)
         $display("PASS ascending_sort_engine");
      else
         $display("FAIL ascending_sort_engine");
      $finish;
   end

endmodule
